FILE: sv/jls_pkg.sv
// Shared types and constants of the complex Jacobi solver.
package jls_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_SIZE_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] KIND_MAT   = 2'd0;
    localparam logic [1:0] KIND_RHS   = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_MAXIT = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic clear;
    } ring_ctl_t;

endpackage

FILE: sv/jls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/jls_cell.sv
// One ring cell: holds guess, next guess and right-hand side of one unknown.
module jls_cell (
    input  logic               aclk,
    input  jls_pkg::ring_ctl_t ctl,
    input  logic               nxt_we,
    input  logic               rhs_we,
    input  jls_pkg::cplx_t     wdata,
    input  jls_pkg::cplx_t     cur_in,
    input  jls_pkg::cplx_t     rhs_in,
    output jls_pkg::cplx_t     cur_out,
    output jls_pkg::cplx_t     rhs_out
);

    jls_pkg::cplx_t cur_reg;
    jls_pkg::cplx_t nxt_reg;
    jls_pkg::cplx_t rhs_reg;

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            cur_reg <= '0;
            nxt_reg <= '0;
        end else begin
            if (ctl.load) begin
                cur_reg <= nxt_reg;
            end else if (ctl.shift) begin
                cur_reg <= cur_in;
            end
            if (nxt_we) begin
                nxt_reg <= wdata;
            end
        end
        if (rhs_we) begin
            rhs_reg <= wdata;
        end else if (ctl.shift) begin
            rhs_reg <= rhs_in;
        end
    end

    assign cur_out = cur_reg;
    assign rhs_out = rhs_reg;

endmodule

FILE: sv/jls_div.sv
// Bit-serial restoring divider: (mag << FRAC_BITS) / den, quotient capped at 2^33.
module jls_div #(
    parameter int FRAC_BITS = jls_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] mag,
    input  logic [63:0] den,
    output logic        done,
    output logic [33:0] quot
);

    localparam int NW = 64 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [63:0]   rem_reg;
    logic [63:0]   den_reg;
    logic [33:0]   q_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [64:0]   trial;
    logic          ge;
    logic [64:0]   diff;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg <= {mag, {FRAC_BITS{1'b0}}};
                den_reg <= den;
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= CW'(NW);
            end else if (cnt_reg != '0) begin
                rem_reg <= ge ? diff[63:0] : trial[63:0];
                if (q_reg >= 34'h2_0000_0000) begin
                    q_reg <= 34'h2_0000_0000;
                end else begin
                    q_reg <= {q_reg[32:0], ge};
                end
                num_reg <= {num_reg[NW-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: sv/jls_sqrt.sv
// Iterative floor square root of a 64-bit value, one result bit per cycle.
module jls_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] val,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] s;

    assign s = r_reg + b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                v_reg   <= val;
                r_reg   <= '0;
                b_reg   <= 64'h4000_0000_0000_0000;
                cnt_reg <= 6'd32;
            end else if (cnt_reg != '0) begin
                if (v_reg >= s) begin
                    v_reg <= v_reg - s;
                    r_reg <= (r_reg >> 1) + b_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                b_reg   <= b_reg >> 2;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

FILE: sv/jacobi_linear_solver.sv
// Complex Jacobi linear solver: ring of guess cells, matrix RAM and iterative units.
// Load items (matrix or right-hand-side writes) are taken one per cycle while idle.
// A start item runs Jacobi sweeps and then emits the solution, one item per unknown.
// The guess vector circulates in a ring of MAX_SIZE cells; each row takes one full
// ring turn against the matrix RAM, then a serial divider pair and a square-root
// unit. The input is not ready during the solve, during output and during the ring
// realignment after it.
module jacobi_linear_solver #(
    parameter int MAX_SIZE  = jls_pkg::MAX_SIZE_DEF,
    parameter int FRAC_BITS = jls_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: row[3:0], col[7:4], value_re[39:8], value_im[71:40]
    input  logic [71:0] s_tdata,
    // s_tuser: kind[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: index[3:0], sol_re[35:4], sol_im[67:36], zero[71:68]
    output logic [71:0] m_tdata,
    // m_tuser: converged[0], fault[1]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW    = $clog2(MAX_SIZE);
    localparam int TW    = $clog2(MAX_SIZE + 2);
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NMAX  = (MAX_SIZE < 16) ? MAX_SIZE : 16;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_ROW, S_NUM, S_MUL, S_DIVS, S_DIVW, S_ERR1, S_ERR2,
        S_ERR3, S_SQW, S_NEXT, S_SWEEP, S_OUTL, S_OUTF, S_OUT, S_ALIGN
    } state_t;

    state_t state_reg;

    logic [4:0]  size_reg;
    logic [15:0] maxit_reg;
    logic [30:0] tol_reg;

    logic [4:0]    n_reg;
    logic [IW-1:0] i_reg;
    logic [TW-1:0] t_reg;
    logic [IW-1:0] pos_reg;
    logic [IW-1:0] k_reg;
    logic [15:0]   sweep_reg;
    logic          fault_reg;
    logic          conv_reg;
    logic [32:0]   err_reg;

    jls_pkg::cplx_t x_reg, diag_reg, rhs_i_reg, cur_i_reg;
    logic v1_reg, d1_reg, v2_reg;
    logic signed [63:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [63:0] acc_re_reg, acc_im_reg;
    logic [31:0] nr_reg, ni_reg;
    logic signed [63:0] dd1_reg, dd2_reg;
    logic signed [63:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [63:0] den_reg;
    logic neg_re_reg, neg_im_reg;
    logic [31:0] q_re_reg, q_im_reg;
    logic [30:0] abs_re_reg, abs_im_reg;
    logic [61:0] sq_re_reg, sq_im_reg;

    logic [3:0]  out_idx_reg;
    logic [31:0] out_re_reg, out_im_reg;
    logic        out_last_reg, out_valid_reg;

    logic s_hs, m_hs, cfg_we;
    logic [1:0] kind;
    logic [3:0] row, col;
    jls_pkg::cplx_t in_val;

    assign s_hs   = s_tvalid && s_tready;
    assign m_hs   = m_tvalid && m_tready;
    assign cfg_we = psel && penable && pwrite && pready;
    assign kind   = s_tuser[1:0];
    assign row    = s_tdata[3:0];
    assign col    = s_tdata[7:4];
    assign in_val = '{re: s_tdata[39:8], im: s_tdata[71:40]};

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= 5'd16;
            maxit_reg <= 16'd100;
            tol_reg   <= 31'd66;
        end else if (cfg_we) begin
            case (paddr[3:2])
                jls_pkg::REG_SIZE:  size_reg  <= pwdata[4:0];
                jls_pkg::REG_MAXIT: maxit_reg <= pwdata[15:0];
                jls_pkg::REG_TOL:   tol_reg   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            jls_pkg::REG_SIZE:  prdata = {27'd0, size_reg};
            jls_pkg::REG_MAXIT: prdata = {16'd0, maxit_reg};
            jls_pkg::REG_TOL:   prdata = {1'b0, tol_reg};
            default:            prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // matrix RAM
    logic          ram_we;
    logic [15:0]   ram_wa_full, ram_ra_full;
    logic [63:0]   ram_q;
    jls_pkg::cplx_t ram_c;

    assign ram_we = (state_reg == S_IDLE) && s_hs && (kind == jls_pkg::KIND_MAT)
                    && (8'(row) < 8'(MAX_SIZE)) && (8'(col) < 8'(MAX_SIZE));
    assign ram_wa_full = 16'(row) * 16'(MAX_SIZE) + 16'(col);
    assign ram_ra_full = 16'(i_reg) * 16'(MAX_SIZE) + 16'(t_reg);
    assign ram_c = ram_q;

    jls_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_mat (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_wa_full[AW-1:0]),
        .wdata (in_val),
        .raddr (ram_ra_full[AW-1:0]),
        .rdata (ram_q)
    );

    // ring of cells
    jls_pkg::ring_ctl_t ring;
    jls_pkg::cplx_t cell_wdata;
    jls_pkg::cplx_t cur_o [MAX_SIZE];
    jls_pkg::cplx_t rhs_o [MAX_SIZE];
    logic row_issue, err_ok;

    assign row_issue = (state_reg == S_ROW) && (8'(t_reg) < 8'(MAX_SIZE));
    assign err_ok    = err_reg < 33'(tol_reg);

    always_comb begin
        ring.shift = row_issue || (state_reg == S_OUTF)
                     || ((state_reg == S_OUT) && m_hs && !out_last_reg)
                     || ((state_reg == S_ALIGN) && (pos_reg != '0));
        ring.load  = (state_reg == S_OUTL) || ((state_reg == S_SWEEP) && !err_ok);
        ring.clear = (state_reg == S_IDLE) && s_hs && (kind == jls_pkg::KIND_START);
    end

    assign cell_wdata = (state_reg == S_ERR1)
                        ? jls_pkg::cplx_t'{re: q_re_reg, im: q_im_reg} : in_val;

    for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
        jls_cell u_cell (
            .aclk    (aclk),
            .ctl     (ring),
            .nxt_we  ((state_reg == S_ERR1) && (8'(i_reg) == 8'(k))),
            .rhs_we  ((state_reg == S_IDLE) && s_hs && (kind == jls_pkg::KIND_RHS)
                      && (8'(row) == 8'(k))),
            .wdata   (cell_wdata),
            .cur_in  (cur_o[(k + 1) % MAX_SIZE]),
            .rhs_in  (rhs_o[(k + 1) % MAX_SIZE]),
            .cur_out (cur_o[k]),
            .rhs_out (rhs_o[k])
        );
    end

    // dividers and square root
    logic signed [64:0] sum_re, sum_im;
    logic [64:0] abs_sum_re, abs_sum_im;
    logic div_start, div_done, div_done_im, sq_start, sq_done;
    logic [33:0] quot_re, quot_im;
    logic [31:0] root;

    assign sum_re = $signed({p1_reg[63], p1_reg}) + $signed({p2_reg[63], p2_reg});
    assign sum_im = $signed({p3_reg[63], p3_reg}) - $signed({p4_reg[63], p4_reg});
    assign abs_sum_re = sum_re[64] ? 65'(-sum_re) : 65'(sum_re);
    assign abs_sum_im = sum_im[64] ? 65'(-sum_im) : 65'(sum_im);
    assign div_start = (state_reg == S_DIVS) && (den_reg != '0);
    assign sq_start  = (state_reg == S_ERR3);

    jls_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .mag(abs_sum_re[63:0]),
        .den(den_reg), .done(div_done), .quot(quot_re)
    );

    jls_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .mag(abs_sum_im[63:0]),
        .den(den_reg), .done(div_done_im), .quot(quot_im)
    );

    jls_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .val(64'(sq_re_reg) + 64'(sq_im_reg)), .done(sq_done), .root(root)
    );

    // datapath helpers
    logic signed [63:0] diff_re, diff_im;
    logic signed [32:0] er, ei;
    logic [32:0] aer, aei;
    logic [33:0] err_sum;

    assign diff_re = $signed({{32{rhs_i_reg.re[31]}}, rhs_i_reg.re}) - acc_re_reg;
    assign diff_im = $signed({{32{rhs_i_reg.im[31]}}, rhs_i_reg.im}) - acc_im_reg;
    assign er  = $signed({q_re_reg[31], q_re_reg}) - $signed({cur_i_reg.re[31], cur_i_reg.re});
    assign ei  = $signed({q_im_reg[31], q_im_reg}) - $signed({cur_i_reg.im[31], cur_i_reg.im});
    assign aer = er[32] ? 33'(-er) : 33'(er);
    assign aei = ei[32] ? 33'(-ei) : 33'(ei);
    assign err_sum = 34'(err_reg) + 34'(root);

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic sat_hit(input logic signed [63:0] v);
        sat_hit = (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    // row pass pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            d1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= row_issue && (8'(t_reg) < 8'(n_reg)) && (8'(t_reg) != 8'(i_reg));
            d1_reg <= row_issue && (8'(t_reg) == 8'(i_reg));
            v2_reg <= v1_reg;
        end
        if (row_issue) begin
            x_reg <= cur_o[0];
            if (8'(t_reg) == 8'(i_reg)) begin
                rhs_i_reg <= rhs_o[0];
                cur_i_reg <= cur_o[0];
            end
        end
        if (v1_reg) begin
            prr_reg <= $signed(ram_c.re) * $signed(x_reg.re);
            pii_reg <= $signed(ram_c.im) * $signed(x_reg.im);
            pri_reg <= $signed(ram_c.re) * $signed(x_reg.im);
            pir_reg <= $signed(ram_c.im) * $signed(x_reg.re);
        end
        if (d1_reg) begin
            diag_reg <= ram_c;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            n_reg         <= 5'd1;
            i_reg         <= '0;
            t_reg         <= '0;
            k_reg         <= '0;
            sweep_reg     <= '0;
            fault_reg     <= 1'b0;
            conv_reg      <= 1'b0;
            err_reg       <= '0;
        end else begin
            if (ring.shift) begin
                pos_reg <= (pos_reg == IW'(MAX_SIZE - 1)) ? '0 : pos_reg + 1'b1;
            end
            if (v2_reg) begin
                acc_re_reg <= acc_re_reg + (prr_reg >>> FRAC_BITS) - (pii_reg >>> FRAC_BITS);
                acc_im_reg <= acc_im_reg + (pri_reg >>> FRAC_BITS) + (pir_reg >>> FRAC_BITS);
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_hs && (kind == jls_pkg::KIND_START)) begin
                        if (size_reg == 5'd0) begin
                            n_reg <= 5'd1;
                        end else if (8'(size_reg) > 8'(NMAX)) begin
                            n_reg <= 5'(NMAX);
                        end else begin
                            n_reg <= size_reg;
                        end
                        sweep_reg <= '0;
                        fault_reg <= 1'b0;
                        conv_reg  <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    i_reg      <= '0;
                    t_reg      <= '0;
                    err_reg    <= '0;
                    acc_re_reg <= '0;
                    acc_im_reg <= '0;
                    state_reg  <= (sweep_reg < maxit_reg) ? S_ROW : S_OUTL;
                end
                S_ROW: begin
                    t_reg <= t_reg + 1'b1;
                    if (8'(t_reg) == 8'(MAX_SIZE + 1)) begin
                        state_reg <= S_NUM;
                    end
                end
                S_NUM: begin
                    nr_reg    <= sat32(diff_re);
                    ni_reg    <= sat32(diff_im);
                    fault_reg <= fault_reg | sat_hit(diff_re) | sat_hit(diff_im);
                    dd1_reg   <= $signed(diag_reg.re) * $signed(diag_reg.re);
                    dd2_reg   <= $signed(diag_reg.im) * $signed(diag_reg.im);
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    p1_reg    <= $signed(nr_reg) * $signed(diag_reg.re);
                    p2_reg    <= $signed(ni_reg) * $signed(diag_reg.im);
                    p3_reg    <= $signed(ni_reg) * $signed(diag_reg.re);
                    p4_reg    <= $signed(nr_reg) * $signed(diag_reg.im);
                    den_reg   <= 64'(dd1_reg) + 64'(dd2_reg);
                    state_reg <= S_DIVS;
                end
                S_DIVS: begin
                    neg_re_reg <= sum_re[64];
                    neg_im_reg <= sum_im[64];
                    if (den_reg == '0) begin
                        fault_reg <= 1'b1;
                        q_re_reg  <= '0;
                        q_im_reg  <= '0;
                        state_reg <= S_ERR1;
                    end else begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (div_done && div_done_im) begin
                        if (neg_re_reg) begin
                            if (quot_re > 34'd2147483648) begin
                                q_re_reg  <= 32'h8000_0000;
                                fault_reg <= 1'b1;
                            end else begin
                                q_re_reg <= 32'(~quot_re + 34'd1);
                            end
                        end else if (quot_re > 34'd2147483647) begin
                            q_re_reg  <= 32'h7FFF_FFFF;
                            fault_reg <= 1'b1;
                        end else begin
                            q_re_reg <= quot_re[31:0];
                        end
                        if (neg_im_reg) begin
                            if (quot_im > 34'd2147483648) begin
                                q_im_reg  <= 32'h8000_0000;
                                fault_reg <= 1'b1;
                            end else begin
                                q_im_reg <= 32'(~quot_im + 34'd1);
                            end
                        end else if (quot_im > 34'd2147483647) begin
                            q_im_reg  <= 32'h7FFF_FFFF;
                            fault_reg <= 1'b1;
                        end else begin
                            q_im_reg <= quot_im[31:0];
                        end
                        state_reg <= S_ERR1;
                    end
                end
                S_ERR1: begin
                    abs_re_reg <= aer[30:0];
                    abs_im_reg <= aei[30:0];
                    if (aer[32] || aer[31] || aei[32] || aei[31]) begin
                        err_reg   <= 33'h1_0000_0000;
                        state_reg <= S_NEXT;
                    end else begin
                        state_reg <= S_ERR2;
                    end
                end
                S_ERR2: begin
                    sq_re_reg <= abs_re_reg * abs_re_reg;
                    sq_im_reg <= abs_im_reg * abs_im_reg;
                    state_reg <= S_ERR3;
                end
                S_ERR3: begin
                    state_reg <= S_SQW;
                end
                S_SQW: begin
                    if (sq_done) begin
                        err_reg   <= (err_sum > 34'h1_0000_0000) ? 33'h1_0000_0000
                                                                 : err_sum[32:0];
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    t_reg      <= '0;
                    acc_re_reg <= '0;
                    acc_im_reg <= '0;
                    if (8'(i_reg) == 8'(n_reg) - 8'd1) begin
                        sweep_reg <= sweep_reg + 1'b1;
                        state_reg <= S_SWEEP;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_ROW;
                    end
                end
                S_SWEEP: begin
                    if (err_ok) begin
                        conv_reg  <= 1'b1;
                        state_reg <= S_OUTL;
                    end else begin
                        state_reg <= S_CHECK;
                    end
                end
                S_OUTL: begin
                    k_reg     <= '0;
                    state_reg <= S_OUTF;
                end
                S_OUTF: begin
                    out_idx_reg   <= 4'(k_reg);
                    out_re_reg    <= cur_o[0].re;
                    out_im_reg    <= cur_o[0].im;
                    out_last_reg  <= 8'(k_reg) == 8'(n_reg) - 8'd1;
                    out_valid_reg <= 1'b1;
                    k_reg         <= k_reg + 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT: begin
                    if (m_hs) begin
                        if (out_last_reg) begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_ALIGN;
                        end else begin
                            out_idx_reg  <= 4'(k_reg);
                            out_re_reg   <= cur_o[0].re;
                            out_im_reg   <= cur_o[0].im;
                            out_last_reg <= 8'(k_reg) == 8'(n_reg) - 8'd1;
                            k_reg        <= k_reg + 1'b1;
                        end
                    end
                end
                S_ALIGN: begin
                    if (pos_reg == '0) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_im_reg, out_re_reg, out_idx_reg};
    assign m_tuser  = {fault_reg, conv_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: sim/tb_top.sv
// Testbench for the complex Jacobi solver: streamed loads and solves, checked against a local predictor.
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] re;
        logic [31:0] im;
        logic        last;
        logic        conv;
        logic        fault;
    } sol_item_t;

    localparam int NMAX = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int  err_count = 0;
    bit  idle_on = 1'b1;
    sol_item_t sol_q[$];

    // predictor state
    int          a_re[NMAX][NMAX], a_im[NMAX][NMAX];
    int          b_re[NMAX], b_im[NMAX];
    bit          a_wr[NMAX][NMAX], b_wr[NMAX];
    logic [4:0]  size_reg = 5'd16;
    logic [15:0] maxit_reg = 16'd100;
    logic [30:0] tol_reg = 31'd66;

    jacobi_linear_solver u_top (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int sat32(longint v, inout bit f);
        if (v > 64'sd2147483647) begin
            f = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            f = 1'b1;
            return 32'h80000000;
        end
        return int'(v);
    endfunction

    function automatic int cdiv(logic signed [65:0] t, logic [63:0] den, inout bit f);
        logic [127:0] mag, q;
        mag = (t < 0) ? 128'(-t) : 128'(t);
        q = (mag << 16) / 128'(den);
        if (t < 0) begin
            if (q > 128'd2147483648) begin
                f = 1'b1;
                return 32'h80000000;
            end
            return int'(-longint'(q[63:0]));
        end
        if (q > 128'd2147483647) begin
            f = 1'b1;
            return 32'h7FFFFFFF;
        end
        return int'(q[31:0]);
    endfunction

    function automatic logic [63:0] sqrt_floor(logic [63:0] v);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic int eff_size();
        int n;
        n = size_reg;
        if (n == 0) n = 1;
        if (n > NMAX) n = NMAX;
        return n;
    endfunction

    // runs the sweeps and queues one solution item per unknown
    function automatic void solve_system();
        longint cur_re[NMAX], cur_im[NMAX];
        int     nx_re[NMAX], nx_im[NMAX];
        int     n, sweeps, nr, ni;
        bit     f, conv;
        longint sr, si, dr, di, er, ei;
        logic [63:0] den, errsum;
        logic signed [65:0] p1, p2;
        sol_item_t it;
        n = eff_size();
        f = 0;
        conv = 0;
        for (int i = 0; i < NMAX; i++) begin
            cur_re[i] = 0; cur_im[i] = 0; nx_re[i] = 0; nx_im[i] = 0;
        end
        sweeps = 0;
        while (sweeps < maxit_reg) begin
            errsum = 0;
            for (int i = 0; i < n; i++) begin
                sr = 0;
                si = 0;
                for (int j = 0; j < n; j++) begin
                    if (j == i) continue;
                    sr += ((longint'(a_re[i][j]) * cur_re[j]) >>> 16)
                        - ((longint'(a_im[i][j]) * cur_im[j]) >>> 16);
                    si += ((longint'(a_re[i][j]) * cur_im[j]) >>> 16)
                        + ((longint'(a_im[i][j]) * cur_re[j]) >>> 16);
                end
                nr = sat32(longint'(b_re[i]) - sr, f);
                ni = sat32(longint'(b_im[i]) - si, f);
                dr = a_re[i][i];
                di = a_im[i][i];
                den = 64'(dr * dr) + 64'(di * di);
                if (den == 0) begin
                    f = 1;
                    nx_re[i] = 0;
                    nx_im[i] = 0;
                    continue;
                end
                p1 = longint'(nr) * dr;
                p2 = longint'(ni) * di;
                nx_re[i] = cdiv(p1 + p2, den, f);
                p1 = longint'(ni) * dr;
                p2 = longint'(nr) * di;
                nx_im[i] = cdiv(p1 - p2, den, f);
            end
            sweeps++;
            for (int i = 0; i < n; i++) begin
                er = longint'(nx_re[i]) - cur_re[i];
                ei = longint'(nx_im[i]) - cur_im[i];
                if (er < 0) er = -er;
                if (ei < 0) ei = -ei;
                if (er >= 64'sd2147483648 || ei >= 64'sd2147483648)
                    errsum = 64'd1 << 32;
                else
                    errsum += sqrt_floor(64'(er * er) + 64'(ei * ei));
                if (errsum > (64'd1 << 32)) errsum = 64'd1 << 32;
            end
            if (errsum < 64'(tol_reg)) begin
                conv = 1;
                break;
            end
            for (int i = 0; i < n; i++) begin
                cur_re[i] = nx_re[i];
                cur_im[i] = nx_im[i];
            end
        end
        for (int i = 0; i < n; i++) begin
            it.idx = 4'(i);
            it.re = nx_re[i];
            it.im = nx_im[i];
            it.last = (i == n - 1);
            it.conv = conv;
            it.fault = f;
            sol_q.insert(sol_q.size(), it);
        end
    endfunction

    task automatic send_item(logic [1:0] kind, int row, int col, int vre, int vim);
        while (idle_on && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {vim, vre, 4'(col), 4'(row)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (kind)
            jls_pkg::KIND_MAT: begin
                a_re[row][col] = vre;
                a_im[row][col] = vim;
                a_wr[row][col] = 1'b1;
            end
            jls_pkg::KIND_RHS: begin
                b_re[row] = vre;
                b_im[row] = vim;
                b_wr[row] = 1'b1;
            end
            jls_pkg::KIND_START: solve_system();
            default: ;
        endcase
    endtask

    function automatic int small_val();
        return int'($urandom_range(262143)) - 131072;
    endfunction

    function automatic int diag_val();
        int v;
        v = int'($urandom_range(524288, 262144));
        return $urandom_range(1) ? v : -v;
    endfunction

    // fills any entry of the active block not yet written, then starts
    task automatic start_solve();
        int n;
        n = eff_size();
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++)
                if (!a_wr[r][c])
                    send_item(jls_pkg::KIND_MAT, r, c,
                              r == c ? diag_val() : small_val() >>> 3,
                              small_val() >>> 3);
            if (!b_wr[r]) send_item(jls_pkg::KIND_RHS, r, 0, small_val(), small_val());
        end
        send_item(jls_pkg::KIND_START, $urandom_range(15), $urandom_range(15),
                  $urandom, $urandom);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sol_q.size() != 0) @(posedge aclk);
        repeat (NMAX + 40) @(posedge aclk);
    endtask

    task automatic reg_write(logic [1:0] regsel, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regsel, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (regsel)
            jls_pkg::REG_SIZE:  size_reg = val[4:0];
            jls_pkg::REG_MAXIT: maxit_reg = val[15:0];
            jls_pkg::REG_TOL:   tol_reg = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int sz, int mi, logic [31:0] tol);
        drain();
        reg_write(jls_pkg::REG_SIZE, sz);
        reg_write(jls_pkg::REG_MAXIT, mi);
        reg_write(jls_pkg::REG_TOL, tol);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge aclk) begin
        sol_item_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (sol_q.size() == 0) begin
                $error("unexpected solution item index %0d", m_tdata[3:0]);
                err_count++;
            end else begin
                e = sol_q.pop_front();
                if (m_tdata[3:0] !== e.idx) begin
                    $error("index exp %0d got %0d", e.idx, m_tdata[3:0]);
                    err_count++;
                end
                if (m_tdata[35:4] !== e.re) begin
                    $error("sol_re exp %h got %h", e.re, m_tdata[35:4]);
                    err_count++;
                end
                if (m_tdata[67:36] !== e.im) begin
                    $error("sol_im exp %h got %h", e.im, m_tdata[67:36]);
                    err_count++;
                end
                if (m_tlast !== e.last) begin
                    $error("last exp %0b got %0b", e.last, m_tlast);
                    err_count++;
                end
                if (m_tuser[0] !== e.conv) begin
                    $error("converged exp %0b got %0b", e.conv, m_tuser[0]);
                    err_count++;
                end
                if (m_tuser[1] !== e.fault) begin
                    $error("fault exp %0b got %0b", e.fault, m_tuser[1]);
                    err_count++;
                end
            end
        end
        m_tready <= !idle_on || ($urandom_range(99) >= 32);
    end

    task automatic test_directed();
        set_config(2, 10, 66);
        send_item(jls_pkg::KIND_MAT, 0, 0, 32'h00040000, 0);
        send_item(jls_pkg::KIND_MAT, 0, 1, 32'h00010000, 32'h00008000);
        send_item(jls_pkg::KIND_MAT, 1, 0, 32'hFFFF0000, 0);
        send_item(jls_pkg::KIND_MAT, 1, 1, 32'h00050000, 32'hFFFE0000);
        send_item(jls_pkg::KIND_RHS, 0, 0, 32'h00020000, 32'hFFFF0000);
        send_item(jls_pkg::KIND_RHS, 1, 0, 32'h00030000, 32'h00010000);
        send_item(jls_pkg::KIND_NONE, 15, 15, 32'hFFFFFFFF, 32'hFFFFFFFF);
        start_solve();
        // extremes: saturation
        set_config(2, 3, 0);
        send_item(jls_pkg::KIND_RHS, 0, 0, 32'h7FFFFFFF, 32'h80000000);
        send_item(jls_pkg::KIND_MAT, 0, 0, 32'h00000001, 0);
        send_item(jls_pkg::KIND_MAT, 0, 1, 32'h80000000, 32'h7FFFFFFF);
        start_solve();
        // zero diagonal
        send_item(jls_pkg::KIND_MAT, 0, 0, 0, 0);
        start_solve();
        // no sweeps
        set_config(2, 0, 66);
        start_solve();
        // size zero acts as one
        set_config(0, 5, 66);
        send_item(jls_pkg::KIND_MAT, 0, 0, 32'h00020000, 32'h00010000);
        start_solve();
    endtask

    task automatic test_max_size();
        set_config(16, 2, 0);
        for (int r = 0; r < NMAX; r++) begin
            for (int c = 0; c < NMAX; c++)
                send_item(jls_pkg::KIND_MAT, r, c,
                          r == c ? diag_val() : small_val() >>> 4,
                          small_val() >>> 4);
            send_item(jls_pkg::KIND_RHS, r, 0, small_val(), small_val());
        end
        start_solve();
        set_config(31, 1, 32'h7FFFFFFF);
        start_solve();
    endtask

    task automatic test_long_limit();
        set_config(2, 65535, 32'h7FFFFFFF);
        send_item(jls_pkg::KIND_MAT, 0, 0, 32'h00040000, 0);
        send_item(jls_pkg::KIND_MAT, 1, 1, 32'h00040000, 0);
        start_solve();
        set_config(3, 65535, 32'h00010000);
        start_solve();
    endtask

    task automatic test_random();
        int sent, n, mode;
        sent = 0;
        for (int rnd = 0; sent < 40; rnd++) begin
            idle_on = (rnd % 8) >= 2;
            mode = $urandom_range(3);
            case ($urandom_range(2))
                0: set_config($urandom_range(4, 1), $urandom_range(8), 0);
                1: set_config($urandom_range(4, 1), $urandom_range(12), $urandom_range(5000));
                default: set_config($urandom_range(5, 1), $urandom_range(6), $urandom);
            endcase
            n = eff_size();
            for (int k = 0; k < n * 3; k++) begin
                int r, c;
                r = $urandom_range(n - 1);
                c = $urandom_range(n - 1);
                case ($urandom_range(9))
                    0: send_item(jls_pkg::KIND_MAT, $urandom_range(15), $urandom_range(15),
                                 $urandom, $urandom);
                    1: send_item(jls_pkg::KIND_NONE, $urandom_range(15), $urandom_range(15),
                                 $urandom, $urandom);
                    2, 3: send_item(jls_pkg::KIND_RHS, r, $urandom_range(15),
                                    mode == 0 ? $urandom : small_val(),
                                    mode == 0 ? $urandom : small_val());
                    default:
                        if (mode == 0)
                            send_item(jls_pkg::KIND_MAT, r, c, $urandom, $urandom);
                        else
                            send_item(jls_pkg::KIND_MAT, r, c,
                                      r == c ? diag_val() : small_val() >>> 3,
                                      r == c ? small_val() : small_val() >>> 3);
                endcase
                sent++;
            end
            start_solve();
            sent++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_max_size();
        test_long_limit();
        test_random();
        drain();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #50000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
